@@ rtl/core/incremental_pid_speed_pwm_defines.svh @@
// assertion macros for the incremental pid speed controller
`ifndef INCREMENTAL_PID_SPEED_PWM_DEFINES_SVH
`define INCREMENTAL_PID_SPEED_PWM_DEFINES_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define IPSP_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ipsp check failed");

// next-cycle implication, checked on every rising clock edge outside reset
`define IPSP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ipsp check failed");

`endif

@@ rtl/core/ipsp_pkg.sv @@
// shared constants, register indexes and helper function of the pid speed controller
package ipsp_pkg;

   localparam int GAIN_W      = 16;
   localparam int CEIL_W      = 4;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int DRIVE_W     = 4;
   localparam int PWM_W       = 6;
   localparam int FRAC_BITS   = 16;

   // configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GAIN_PROPORTIONAL = 3'd0,
      CSR_GAIN_INTEGRAL     = 3'd1,
      CSR_GAIN_DERIVATIVE   = 3'd2,
      CSR_LIMIT_FRACTION    = 3'd3,
      CSR_DRIVE_CEILING     = 3'd4
   } csr_index_type;

   // register reset values
   localparam logic [GAIN_W-1:0] GAIN_PROPORTIONAL_RST = 16'd13107;
   localparam logic [GAIN_W-1:0] GAIN_INTEGRAL_RST     = 16'd0;
   localparam logic [GAIN_W-1:0] GAIN_DERIVATIVE_RST   = 16'd1966;
   localparam logic [GAIN_W-1:0] LIMIT_FRACTION_RST    = 16'd19661;
   localparam logic [CEIL_W-1:0] DRIVE_CEILING_RST     = 4'd15;

   localparam logic [PWM_W-1:0] PWM_TOP = 6'd50;

   // compare value: top minus ceil(1.5 * drive)
   function automatic logic [PWM_W-1:0] pwm_compare_f(input logic [DRIVE_W-1:0] drive);
      logic [PWM_W-1:0] tri_plus;
      tri_plus = {2'b00, drive} * 6'd3 + 6'd1;
      return PWM_TOP - {1'b0, tri_plus[PWM_W-1:1]};
   endfunction

endpackage

@@ rtl/core/incremental_pid_speed_pwm.sv @@
// Incremental PID speed controller with drive level and PWM compare output.
// rsp_valid rises once the req transfer has passed the input register, product
// stage and accumulate/clamp stage with its result register; a stall can hold
// it in any of them. Throughput: one item per cycle while rsp_ready holds; set
// by the per-channel output accumulator update in the last stage. Reset:
// registers to defaults, channel history to zero, pipeline empty.
`include "incremental_pid_speed_pwm_defines.svh"

module incremental_pid_speed_pwm #(
   parameter int CHANNELS   = 2,
   parameter int SPEED_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // configuration write port
   input  logic                                  csr_write_en,
   input  logic [ipsp_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [ipsp_pkg::CSR_DATA_W-1:0]       csr_write_data,
   // input channel
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_mode,
   input  logic signed [SPEED_BITS-1:0]          req_target_speed,
   input  logic signed [SPEED_BITS-1:0]          req_measured_speed,
   // result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_channel,
   output logic [ipsp_pkg::DRIVE_W-1:0]          rsp_drive_level,
   output logic [ipsp_pkg::PWM_W-1:0]            rsp_pwm_compare
);

   localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int EW    = SPEED_BITS + 1;                 // error
   localparam int D1W   = EW + 1;                         // e - e1
   localparam int D2W   = EW + 3;                         // e - 2e1 + e2
   localparam int PW    = D2W + ipsp_pkg::GAIN_W + 1;     // gain products
   localparam int LIMW  = SPEED_BITS + ipsp_pkg::GAIN_W + 1;
   localparam int OUTW  = LIMW + 1;                       // stored output, holds -lim
   localparam int SUMW  = ((OUTW > PW) ? OUTW : PW) + 2;
   localparam int IPW   = SUMW - ipsp_pkg::FRAC_BITS;

   // configuration registers
   logic [ipsp_pkg::GAIN_W-1:0] kp_ff, ki_ff, kd_ff, lf_ff;
   logic [ipsp_pkg::CEIL_W-1:0] ceil_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff   <= ipsp_pkg::GAIN_PROPORTIONAL_RST;
         ki_ff   <= ipsp_pkg::GAIN_INTEGRAL_RST;
         kd_ff   <= ipsp_pkg::GAIN_DERIVATIVE_RST;
         lf_ff   <= ipsp_pkg::LIMIT_FRACTION_RST;
         ceil_ff <= ipsp_pkg::DRIVE_CEILING_RST;
      end else if (csr_write_en) begin
         case (ipsp_pkg::csr_index_type'(csr_index))
            ipsp_pkg::CSR_GAIN_PROPORTIONAL: kp_ff <= csr_write_data;
            ipsp_pkg::CSR_GAIN_INTEGRAL:     ki_ff <= csr_write_data;
            ipsp_pkg::CSR_GAIN_DERIVATIVE:   kd_ff <= csr_write_data;
            ipsp_pkg::CSR_LIMIT_FRACTION:    lf_ff <= csr_write_data;
            ipsp_pkg::CSR_DRIVE_CEILING:     ceil_ff <= csr_write_data[ipsp_pkg::CEIL_W-1:0];
            default: ;
         endcase
      end
   end

   // pipeline control
   logic s1_valid_ff, s2_valid_ff, rsp_valid_ff;
   logic adv_a, adv_b;

   assign adv_b     = s2_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign adv_a     = s1_valid_ff && (!s2_valid_ff || adv_b);
   assign req_ready = !s1_valid_ff || adv_a;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) s1_valid_ff <= req_valid;
         if (!s2_valid_ff || adv_b) s2_valid_ff <= adv_a;
         if (!rsp_valid_ff || rsp_ready) rsp_valid_ff <= adv_b;
      end
   end

   // input register
   logic                         s1_mode_ff;
   logic signed [SPEED_BITS-1:0] s1_target_ff, s1_measured_ff;

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_mode_ff     <= req_mode;
         s1_target_ff   <= req_target_speed;
         s1_measured_ff <= req_measured_speed;
      end
   end

   // per-channel history
   logic signed [EW-1:0]   prev_err_ff  [CHANNELS];
   logic signed [EW-1:0]   prev_err2_ff [CHANNELS];
   logic signed [OUTW-1:0] prev_out_ff  [CHANNELS];

   // product stage: error, differences and gain products
   logic [CH_W-1:0]        idx_a;
   logic signed [EW-1:0]   err_a, e1_a, e2_a;
   logic signed [D1W-1:0]  d1_a;
   logic signed [D2W-1:0]  d2_a;
   logic signed [PW-1:0]   p_prop_in, p_int_in, p_der_in;
   logic signed [LIMW-1:0] lim_in;

   assign idx_a = (CHANNELS > 1) ? CH_W'(s1_mode_ff) : '0;
   assign e1_a  = prev_err_ff[idx_a];
   assign e2_a  = prev_err2_ff[idx_a];
   assign err_a = EW'(s1_target_ff) - EW'(s1_measured_ff);
   assign d1_a  = D1W'(err_a) - D1W'(e1_a);
   assign d2_a  = D2W'(err_a) - (D2W'(e1_a) <<< 1) + D2W'(e2_a);

   assign p_prop_in = PW'($signed({1'b0, kp_ff})) * PW'(d1_a);
   assign p_int_in  = PW'($signed({1'b0, ki_ff})) * PW'(err_a);
   assign p_der_in  = PW'($signed({1'b0, kd_ff})) * PW'(d2_a);
   assign lim_in    = LIMW'($signed({1'b0, lf_ff})) * LIMW'(s1_target_ff);

   logic                   s2_mode_ff;
   logic signed [PW-1:0]   s2_prop_ff, s2_int_ff, s2_der_ff;
   logic signed [LIMW-1:0] s2_lim_ff;

   always_ff @(posedge clock) begin
      if (adv_a) begin
         s2_mode_ff <= s1_mode_ff;
         s2_prop_ff <= p_prop_in;
         s2_int_ff  <= p_int_in;
         s2_der_ff  <= p_der_in;
         s2_lim_ff  <= lim_in;
      end
   end

   // accumulate stage: sum, clamp against target, drive level
   logic [CH_W-1:0]            idx_b;
   logic signed [SUMW-1:0]     acc_b, lim_b, neg_lim_b, clamp_hi_b, clamp_b;
   logic [IPW-1:0]             ipart_b;
   logic [ipsp_pkg::DRIVE_W-1:0] drive_in;

   assign idx_b = (CHANNELS > 1) ? CH_W'(s2_mode_ff) : '0;
   assign acc_b = SUMW'(prev_out_ff[idx_b]) + SUMW'(s2_prop_ff)
                + SUMW'(s2_int_ff) + SUMW'(s2_der_ff);
   assign lim_b      = SUMW'(s2_lim_ff);
   assign neg_lim_b  = -lim_b;
   assign clamp_hi_b = (acc_b >= lim_b) ? lim_b : acc_b;
   assign clamp_b    = (clamp_hi_b <= neg_lim_b) ? neg_lim_b : clamp_hi_b;
   assign ipart_b    = clamp_b[SUMW-1:ipsp_pkg::FRAC_BITS];

   always_comb begin
      if (clamp_b[SUMW-1]) begin
         drive_in = '0;
      end else if (ipart_b >= IPW'(ceil_ff)) begin
         drive_in = ceil_ff;
      end else begin
         drive_in = ipart_b[ipsp_pkg::DRIVE_W-1:0];
      end
   end

   // history update, errors at the product stage, output at the last stage
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            prev_err_ff[i]  <= '0;
            prev_err2_ff[i] <= '0;
            prev_out_ff[i]  <= '0;
         end
      end else begin
         if (adv_a) begin
            prev_err2_ff[idx_a] <= e1_a;
            prev_err_ff[idx_a]  <= err_a;
         end
         if (adv_b) begin
            prev_out_ff[idx_b] <= clamp_b[OUTW-1:0];
         end
      end
   end

   // result register
   logic                         rsp_channel_ff;
   logic [ipsp_pkg::DRIVE_W-1:0] rsp_drive_ff;
   logic [ipsp_pkg::PWM_W-1:0]   rsp_pwm_ff;

   always_ff @(posedge clock) begin
      if (adv_b) begin
         rsp_channel_ff <= s2_mode_ff;
         rsp_drive_ff   <= drive_in;
         rsp_pwm_ff     <= ipsp_pkg::pwm_compare_f(drive_in);
      end
   end

   assign rsp_channel     = rsp_channel_ff;
   assign rsp_drive_level = rsp_drive_ff;
   assign rsp_pwm_compare = rsp_pwm_ff;

   // checks
   `IPSP_ASSERT_NEXT(a_accept_fills_s1, req_valid && req_ready, s1_valid_ff)
   `IPSP_ASSERT_NEXT(a_acc_update_gives_rsp, adv_b, rsp_valid_ff)
   `IPSP_ASSERT_NOW(a_pwm_drive, rsp_valid_ff, rsp_pwm_ff == ipsp_pkg::pwm_compare_f(rsp_drive_ff))
   `IPSP_ASSERT_NOW(a_no_stage_skip, adv_a && s2_valid_ff, adv_b)

endmodule

@@ tb/tb_incremental_pid_speed_pwm.sv @@
// testbench for the incremental pid speed controller: predicts each drive result and checks it
`timescale 1ns / 1ps

module tb_incremental_pid_speed_pwm;

   localparam int     SPEED_W     = 16;
   localparam int     CYCLE_LIMIT = 400000;
   localparam longint Q16_ONE     = longint'(1) << ipsp_pkg::FRAC_BITS;

   typedef logic [ipsp_pkg::GAIN_W-1:0]      gain_type;
   typedef logic [ipsp_pkg::CEIL_W-1:0]      ceil_type;
   typedef logic [ipsp_pkg::CSR_DATA_W-1:0]  csr_data_type;
   typedef logic [ipsp_pkg::CSR_INDEX_W-1:0] csr_index_word_type;
   typedef logic [ipsp_pkg::DRIVE_W-1:0]     drive_type;
   typedef logic [ipsp_pkg::PWM_W-1:0]       pwm_type;
   typedef logic signed [SPEED_W-1:0]        speed_type;

   localparam speed_type SPEED_MAX = 16'sh7FFF;
   localparam speed_type SPEED_MIN = 16'sh8000;

   // indexes past the last register, writes there must be ignored
   localparam csr_index_word_type CSR_SPARE_FIRST = 3'd5;
   localparam csr_index_word_type CSR_SPARE_LAST  = 3'd7;

   typedef struct packed {
      logic      channel;
      drive_type drive_level;
      pwm_type   pwm_compare;
   } drive_result_type;

   logic               clock              = 1'b0;
   logic               reset              = 1'b1;
   logic               csr_write_en       = 1'b0;
   csr_index_word_type csr_index          = '0;
   csr_data_type       csr_write_data     = '0;
   logic               req_valid          = 1'b0;
   logic               req_ready;
   logic               req_mode           = 1'b0;
   speed_type          req_target_speed   = '0;
   speed_type          req_measured_speed = '0;
   logic               rsp_valid;
   logic               rsp_ready          = 1'b0;
   logic               rsp_channel;
   drive_type          rsp_drive_level;
   pwm_type            rsp_pwm_compare;

   // mirrored register contents
   gain_type kp_q16    = ipsp_pkg::GAIN_PROPORTIONAL_RST;
   gain_type ki_q16    = ipsp_pkg::GAIN_INTEGRAL_RST;
   gain_type kd_q16    = ipsp_pkg::GAIN_DERIVATIVE_RST;
   gain_type limit_q16 = ipsp_pkg::LIMIT_FRACTION_RST;
   ceil_type ceiling   = ipsp_pkg::DRIVE_CEILING_RST;

   // per-channel loop history: last two errors and the held signed Q18.16 output
   longint last_error  [2] = '{0, 0};
   longint older_error [2] = '{0, 0};
   longint held_output [2] = '{0, 0};

   drive_result_type pending_drive [$];

   int error_count    = 0;
   int cycle_count    = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int setting_round  = 0;

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   incremental_pid_speed_pwm DUT (
      .clock              (clock),
      .reset              (reset),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_mode           (req_mode),
      .req_target_speed   (req_target_speed),
      .req_measured_speed (req_measured_speed),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_channel        (rsp_channel),
      .rsp_drive_level    (rsp_drive_level),
      .rsp_pwm_compare    (rsp_pwm_compare)
   );

   task automatic report_mismatch(input string msg);
      $display("%0t ns: %s", $time, msg);
      error_count++;
   endtask

   // one control tick: advance the channel's output and derive drive and compare
   function automatic drive_result_type pid_drive_step(input logic mode,
                                                       input speed_type target,
                                                       input speed_type measured);
      drive_result_type res;
      int               ch;
      longint           tgt, err, e1, e2, acc, bound, level;
      ch  = mode;
      tgt = target;
      err = tgt - longint'(measured);
      e1  = last_error[ch];
      e2  = older_error[ch];
      acc = held_output[ch]
          + longint'(kp_q16) * (err - e1)
          + longint'(ki_q16) * err
          + longint'(kd_q16) * (err - 2 * e1 + e2);
      // clamp against the target, upper test first, then the lower one
      bound = longint'(limit_q16) * tgt;
      if (acc >= bound) acc = bound;
      if (acc <= -bound) acc = -bound;
      older_error[ch] = e1;
      last_error[ch]  = err;
      held_output[ch] = acc;
      // integer part truncated toward zero, then saturated to 0..ceiling
      level = acc / Q16_ONE;
      if (level >= longint'(ceiling)) level = longint'(ceiling);
      if (level <= 0) level = 0;
      res.channel     = mode;
      res.drive_level = level[ipsp_pkg::DRIVE_W-1:0];
      res.pwm_compare = pwm_type'(longint'(ipsp_pkg::PWM_TOP) - (3 * level + 1) / 2);
      return res;
   endfunction

   // one input transfer, with an optional idle gap ahead of it
   task automatic send_tick(input logic mode,
                            input speed_type target,
                            input speed_type measured);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid          <= 1'b1;
      req_mode           <= mode;
      req_target_speed   <= target;
      req_measured_speed <= measured;
      do @(posedge clock); while (!req_ready);
      pending_drive.push_back(pid_drive_step(mode, target, measured));
   endtask

   task automatic wait_for_idle();
      req_valid <= 1'b0;
      while (pending_drive.size() != 0) @(posedge clock);
   endtask

   // register write, mirrored once the edge has taken it
   task automatic write_reg(input csr_index_word_type index,
                            input csr_data_type value);
      csr_write_en   <= 1'b1;
      csr_index      <= index;
      csr_write_data <= value;
      @(posedge clock);
      case (index)
         ipsp_pkg::CSR_GAIN_PROPORTIONAL: kp_q16    = value;
         ipsp_pkg::CSR_GAIN_INTEGRAL:     ki_q16    = value;
         ipsp_pkg::CSR_GAIN_DERIVATIVE:   kd_q16    = value;
         ipsp_pkg::CSR_LIMIT_FRACTION:    limit_q16 = value;
         ipsp_pkg::CSR_DRIVE_CEILING:     ceiling   = value[ipsp_pkg::CEIL_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input gain_type kp, input gain_type ki,
                                 input gain_type kd, input gain_type lim,
                                 input ceil_type top_level);
      csr_data_type ceiling_word;
      // junk above the ceiling field must be dropped
      ceiling_word                         = csr_data_type'($urandom);
      ceiling_word[ipsp_pkg::CEIL_W-1:0]   = top_level;
      write_reg(ipsp_pkg::CSR_GAIN_PROPORTIONAL, kp);
      write_reg(ipsp_pkg::CSR_GAIN_INTEGRAL, ki);
      write_reg(ipsp_pkg::CSR_GAIN_DERIVATIVE, kd);
      write_reg(ipsp_pkg::CSR_LIMIT_FRACTION, lim);
      write_reg(ipsp_pkg::CSR_DRIVE_CEILING, ceiling_word);
      csr_write_en <= 1'b0;
   endtask

   // result checking
   always @(posedge clock) begin : check_drive
      drive_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_drive.size() == 0) begin
            report_mismatch($sformatf("drive transfer with nothing outstanding, channel %0d",
                                      rsp_channel));
         end else begin
            want = pending_drive.pop_front();
            if (rsp_channel !== want.channel)
               report_mismatch($sformatf("channel got %0d expected %0d",
                                         rsp_channel, want.channel));
            if (rsp_drive_level !== want.drive_level)
               report_mismatch($sformatf("drive_level got %0d expected %0d (channel %0d)",
                                         rsp_drive_level, want.drive_level, want.channel));
            if (rsp_pwm_compare !== want.pwm_compare)
               report_mismatch($sformatf("pwm_compare got %0d expected %0d (channel %0d)",
                                         rsp_pwm_compare, want.pwm_compare, want.channel));
         end
      end
   end

   // receiver stalls
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // register defaults straight after reset
   task automatic test_defaults_after_reset();
      send_tick(1'b0, 16'sd100, 16'sd0);
      send_tick(1'b0, 16'sd100, 16'sd40);
      send_tick(1'b1, 16'sd50, 16'sd0);
      send_tick(1'b1, 16'sd50, 16'sd60);
      wait_for_idle();
   endtask

   // extremes of target and measured speed on both channels
   task automatic test_field_extremes();
      send_tick(1'b0, SPEED_MAX, SPEED_MIN);
      send_tick(1'b1, SPEED_MIN, SPEED_MAX);
      send_tick(1'b0, SPEED_MIN, SPEED_MIN);
      send_tick(1'b1, SPEED_MAX, SPEED_MAX);
      send_tick(1'b0, 16'sd0, 16'sd0);
      wait_for_idle();
   endtask

   // clamp order, negative target, negative output, ceiling saturation
   task automatic test_clamp_and_saturation();
      apply_settings('1, '1, '1, '1, ipsp_pkg::DRIVE_CEILING_RST);
      send_tick(1'b0, 16'sd1000, 16'sd0);
      send_tick(1'b1, -16'sd10, 16'sd0);
      send_tick(1'b0, 16'sd100, 16'sd400);
      send_tick(1'b1, 16'sd0, 16'sd5);
      wait_for_idle();
      // zero ceiling forces the drive to zero
      apply_settings(16'd4096, 16'd0, 16'd0, 16'h8000, 4'd0);
      send_tick(1'b0, 16'sd200, 16'sd0);
      send_tick(1'b1, -16'sd6, 16'sd0);
      wait_for_idle();
   endtask

   // writes past the last register leave every setting alone
   task automatic test_spare_index_writes();
      apply_settings(16'd13107, 16'd3000, 16'd1966, 16'd19661, 4'd9);
      @(posedge clock);
      write_reg(CSR_SPARE_FIRST, 16'hFFFF);
      write_reg(CSR_SPARE_FIRST + 3'd1, 16'h0000);
      write_reg(CSR_SPARE_LAST, 16'hFFFF);
      csr_write_en <= 1'b0;
      send_tick(1'b0, 16'sd60, 16'sd10);
      send_tick(1'b1, 16'sd40, 16'sd45);
      send_tick(1'b0, 16'sd60, 16'sd30);
      wait_for_idle();
   endtask

   // random traffic under one idling pattern, three register settings in turn
   task automatic test_random_traffic(input int idle_pct, input int stall_pct);
      int   run_left     [2];
      int   run_target   [2];
      int   run_measured [2];
      int   count, sent, roll;
      logic ch;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (3) begin
         // moderate gains, any gains, then a corner setting or the reset defaults
         case (setting_round % 3)
            0: apply_settings(gain_type'($urandom_range(26000)),
                              gain_type'($urandom_range(8000)),
                              gain_type'($urandom_range(8000)),
                              gain_type'($urandom_range(65535, 8000)),
                              ceil_type'($urandom_range(15, 6)));
            1: apply_settings(gain_type'($urandom), gain_type'($urandom),
                              gain_type'($urandom), gain_type'($urandom),
                              ceil_type'($urandom));
            default: begin
               if (setting_round == 2)
                  apply_settings('1, '1, '1, '1, '1);
               else if (setting_round == 5)
                  apply_settings('0, '0, '0, '0, '0);
               else
                  apply_settings(ipsp_pkg::GAIN_PROPORTIONAL_RST, ipsp_pkg::GAIN_INTEGRAL_RST,
                                 ipsp_pkg::GAIN_DERIVATIVE_RST, ipsp_pkg::LIMIT_FRACTION_RST,
                                 ipsp_pkg::DRIVE_CEILING_RST);
            end
         endcase
         count    = (setting_round % 3 == 2) ? 60 : 250;
         run_left = '{0, 0};
         sent     = 0;
         while (sent < count) begin
            ch   = ($urandom_range(1) != 0);
            roll = $urandom_range(99);
            if (roll < 15) begin
               // noise over the whole field range
               send_tick(ch, speed_type'($urandom), speed_type'($urandom));
            end else if (roll < 25) begin
               send_tick(ch, speed_type'(int'($urandom_range(4000)) - 2000),
                         speed_type'(int'($urandom_range(4000)) - 2000));
            end else begin
               // a run of ticks with the measured speed settling toward the target
               if (run_left[ch] == 0) begin
                  run_left[ch]     = $urandom_range(12, 4);
                  run_target[ch]   = ($urandom_range(9) == 0) ? -int'($urandom_range(80))
                                                              : int'($urandom_range(300));
                  run_measured[ch] = ($urandom_range(1) == 0) ? 0
                                   : run_target[ch] + int'($urandom_range(60)) - 30;
               end
               run_measured[ch] += (run_target[ch] - run_measured[ch]) / 3
                                 + int'($urandom_range(16)) - 8;
               send_tick(ch, speed_type'(run_target[ch]), speed_type'(run_measured[ch]));
               run_left[ch]--;
            end
            sent++;
         end
         wait_for_idle();
         setting_round++;
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_defaults_after_reset();
      test_field_extremes();
      test_clamp_and_saturation();
      test_spare_index_writes();
      test_random_traffic(25, 88);
      test_random_traffic(88, 25);
      test_random_traffic(0, 0);
      // leave room for any stray transfer
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
